// ===== rtl/clkmte_pkg.sv =====
// ----------------------------------------------------------------------------
// clkmte_pkg
// Shared types, codes and digit helpers for the clock menu and time editor.
// ----------------------------------------------------------------------------
`default_nettype none

package clkmte_pkg;

	// stream widths, packed fields padded to whole bytes
	localparam int ITEM_W = 56;
	localparam int RES_W  = 80;

	// tube codes
	localparam logic [3:0] CODE_POINT = 4'd10;
	localparam logic [3:0] CODE_SEP   = 4'd11;

	// key codes
	localparam logic [1:0] KEY_NONE  = 2'd0;
	localparam logic [1:0] KEY_NEXT  = 2'd1;
	localparam logic [1:0] KEY_PLUS  = 2'd2;
	localparam logic [1:0] KEY_ENTER = 2'd3;

	// ui state as reported on the result
	localparam logic [1:0] UI_NORMAL = 2'd0;
	localparam logic [1:0] UI_MENU   = 2'd1;
	localparam logic [1:0] UI_TIME   = 2'd2;
	localparam logic [1:0] UI_DATE   = 2'd3;

	// display modes
	localparam logic [2:0] MODE_TIME    = 3'd0;
	localparam logic [2:0] MODE_WL_TIME = 3'd1;
	localparam logic [2:0] MODE_DATE    = 3'd2;
	localparam logic [2:0] MODE_WL_DATE = 3'd3;
	localparam logic [2:0] MODE_TEMP    = 3'd4;
	localparam logic [2:0] MODE_WL      = 3'd5;

	// menu entries and edit cursor positions
	localparam logic [2:0] MENU_TIME = 3'd0;
	localparam logic [2:0] MENU_DATE = 3'd1;
	localparam logic [2:0] MENU_BACK = 3'd2;
	localparam logic [2:0] TCUR_HOUR_T = 3'd0;
	localparam logic [2:0] TCUR_HOUR_U = 3'd1;
	localparam logic [2:0] TCUR_MIN_T  = 3'd2;
	localparam logic [2:0] TCUR_MIN_U  = 3'd3;
	localparam logic [2:0] TCUR_SEC_T  = 3'd4;
	localparam logic [2:0] TCUR_SEC_U  = 3'd5;
	localparam logic [2:0] TCUR_MENU   = 3'd6;
	localparam logic [2:0] TCUR_SAVE   = 3'd7;
	localparam logic [2:0] DCUR_YEAR_T = 3'd0;
	localparam logic [2:0] DCUR_YEAR_U = 3'd1;
	localparam logic [2:0] DCUR_MONTH  = 3'd2;
	localparam logic [2:0] DCUR_DAY_T  = 3'd3;
	localparam logic [2:0] DCUR_DAY_U  = 3'd4;
	localparam logic [2:0] DCUR_MENU   = 3'd5;
	localparam logic [2:0] DCUR_SAVE   = 3'd6;
	localparam logic [2:0] DCUR_LAST   = 3'd7;

	// controller state, one-hot
	typedef enum logic [3:0] {
		ST_NORMAL = 4'b0001,
		ST_MENU   = 4'b0010,
		ST_TIME   = 4'b0100,
		ST_DATE   = 4'b1000
	} ui_state_t;

	// input item, key in the lowest bits
	typedef struct packed {
		logic [3:0] temp_hundredths;
		logic [3:0] temp_tenths;
		logic [3:0] temp_units;
		logic [3:0] temp_tens;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [1:0] key;
	} item_t;

	// controller outcome of one step
	typedef struct packed {
		logic [4:0] edit_day;
		logic [3:0] edit_month;
		logic [6:0] edit_year;
		logic [5:0] edit_second;
		logic [5:0] edit_minute;
		logic [4:0] edit_hour;
		logic       save_strobe;
		logic [2:0] cursor;
		logic [2:0] display_mode;
		logic [1:0] ui_state;
	} ctrl_res_t;

	// full result item, digits in the lowest bits
	typedef struct packed {
		ctrl_res_t   ctrl;
		logic [31:0] digits;
	} result_t;

	// quotient by ten through reciprocal, exact for any 8-bit value
	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = {8'd0, v} * 16'd205;
		return p[15:11];
	endfunction

	function automatic logic [7:0] mod10(input logic [7:0] v);
		logic [7:0] q10;
		q10 = {3'd0, div10(v)} * 8'd10;
		return v - q10;
	endfunction

	// tens step: wrap to units when the tens digit is at its top, else add ten
	function automatic logic [7:0] step_tens(input logic [7:0] v, input logic [4:0] top);
		return (div10(v) == top) ? mod10(v) : v + 8'd10;
	endfunction

	// units step: units nine falls back to the tens value, else add one
	function automatic logic [7:0] step_units(input logic [7:0] v);
		return (mod10(v) == 8'd9) ? v - 8'd9 : v + 8'd1;
	endfunction

	// worldline rows, tube 0 in the top nibble
	function automatic logic [31:0] wl_row(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:    r = 32'h0A571024;
			5'd1:    r = 32'h0A571015;
			5'd2:    r = 32'h0A571046;
			5'd3:    r = 32'h0A523299;
			5'd4:    r = 32'h0A456903;
			5'd5:    r = 32'h0A409420;
			5'd6:    r = 32'h0A337187;
			5'd7:    r = 32'h0A334581;
			5'd8:    r = 32'h1A130426;
			5'd9:    r = 32'h1A130205;
			5'd10:   r = 32'h1A130212;
			5'd11:   r = 32'h1A130238;
			5'd12:   r = 32'h1A129848;
			5'd13:   r = 32'h0A275349;
			5'd14:   r = 32'h2A615074;
			5'd15:   r = 32'h1A048596;
			5'd16:   r = 32'h1A048728;
			5'd17:   r = 32'h3A130238;
			5'd18:   r = 32'h3A182879;
			5'd19:   r = 32'h3A372329;
			5'd20:   r = 32'h3A406288;
			5'd21:   r = 32'h3A600104;
			5'd22:   r = 32'h3A667293;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/clkmte_ctrl.sv =====
// ----------------------------------------------------------------------------
// clkmte_ctrl
// Panel controller: normal/menu/time edit/date edit states, display mode,
// cursor and the shadow time and date with digit stepping and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module clkmte_ctrl
	import clkmte_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,   // apply item this cycle
	input  wire item_t     item,
	output      ctrl_res_t res     // outcome of the step, state after it
);

	ui_state_t  state_q, state_d;
	logic [2:0] mode_q, mode_d;
	logic [2:0] cursor_q, cursor_d;
	logic       loaded_q, loaded_d;
	logic [4:0] hour_q;
	logic [5:0] minute_q, second_q;
	logic [6:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;

	// wide working copies so a step may overshoot before the clamp
	logic [7:0] h8, m8, s8, y8, d8;
	logic [3:0] mo;
	logic [7:0] y_step;
	logic [2:0] mc;
	logic       save;
	logic       edit;

	// next state
	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		cursor_d = cursor_q;
		loaded_d = loaded_q;
		save     = 1'b0;
		h8       = {3'd0, hour_q};
		m8       = {2'd0, minute_q};
		s8       = {2'd0, second_q};
		y8       = {1'd0, year_q};
		mo       = month_q;
		d8       = {3'd0, day_q};
		y_step   = 8'd0;
		mc       = cursor_q;
		edit     = (state_q == ST_TIME) || (state_q == ST_DATE);

		// shadow load on first pass in an edit state
		if (edit && !loaded_q) begin
			loaded_d = 1'b1;
			h8 = {3'd0, item.hour};
			m8 = {2'd0, item.minute};
			s8 = {2'd0, item.second};
			y8 = {1'd0, item.year};
			mo = item.month;
			d8 = {3'd0, item.day};
		end

		case (state_q)
			ST_NORMAL: begin
				if (item.key == KEY_NEXT) begin
					mode_d = (mode_q == MODE_WL) ? MODE_TIME : mode_q + 3'd1;
				end else if (item.key == KEY_PLUS) begin
					mode_d = MODE_TIME;
				end else if (item.key == KEY_ENTER) begin
					state_d = ST_MENU;
				end
			end
			ST_MENU: begin
				mc = (cursor_q > MENU_BACK) ? MENU_TIME : cursor_q;
				cursor_d = mc;
				if (item.key == KEY_NEXT) begin
					cursor_d = (mc == MENU_BACK) ? MENU_TIME : mc + 3'd1;
				end else if (item.key == KEY_PLUS) begin
					cursor_d = (mc == MENU_TIME) ? MENU_BACK : mc - 3'd1;
				end else if (item.key == KEY_ENTER) begin
					state_d  = (mc == MENU_TIME) ? ST_TIME
					         : (mc == MENU_DATE) ? ST_DATE : ST_NORMAL;
					cursor_d = MENU_TIME;
				end
			end
			ST_TIME: begin
				if (item.key == KEY_NEXT) begin
					cursor_d = cursor_q + 3'd1;
				end else if (item.key == KEY_PLUS) begin
					case (cursor_q)
						TCUR_HOUR_T: h8 = step_tens(h8, 5'd2);
						TCUR_HOUR_U: h8 = step_units(h8);
						TCUR_MIN_T:  m8 = step_tens(m8, 5'd5);
						TCUR_MIN_U:  m8 = step_units(m8);
						TCUR_SEC_T:  s8 = step_tens(s8, 5'd5);
						TCUR_SEC_U:  s8 = step_units(s8);
						default:     ;
					endcase
				end else if (item.key == KEY_ENTER &&
				             (cursor_q == TCUR_MENU || cursor_q == TCUR_SAVE)) begin
					if (cursor_q == TCUR_MENU) begin
						state_d = ST_MENU;
					end else begin
						state_d = ST_NORMAL;
						save    = 1'b1;
					end
					cursor_d = TCUR_HOUR_T;
					loaded_d = 1'b0;
				end
				// time clamps
				if (h8 > 8'd23) h8 = 8'd20;
				if (m8 > 8'd59) m8 = 8'd59;
				if (s8 > 8'd59) s8 = 8'd59;
			end
			ST_DATE: begin
				if (item.key == KEY_NEXT) begin
					// advance modulo seven
					cursor_d = (cursor_q == DCUR_SAVE) ? DCUR_YEAR_T
					         : (cursor_q == DCUR_LAST) ? DCUR_YEAR_U : cursor_q + 3'd1;
				end else if (item.key == KEY_PLUS) begin
					case (cursor_q)
						DCUR_YEAR_T: begin
							y_step = step_tens(y8, 5'd9);
							y8 = {1'b0, y_step[6:0]};
						end
						DCUR_YEAR_U: begin
							y_step = step_units(y8);
							y8 = {1'b0, y_step[6:0]};
						end
						DCUR_MONTH:  mo = (mo < 4'd12) ? mo + 4'd1 : 4'd1;
						DCUR_DAY_T:  d8 = step_tens(d8, 5'd3);
						DCUR_DAY_U:  d8 = step_units(d8);
						default:     ;
					endcase
				end else if (item.key == KEY_ENTER &&
				             (cursor_q == DCUR_MENU || cursor_q == DCUR_SAVE)) begin
					if (cursor_q == DCUR_MENU) begin
						state_d = ST_MENU;
					end else begin
						state_d = ST_NORMAL;
						save    = 1'b1;
					end
					cursor_d = DCUR_YEAR_T;
					loaded_d = 1'b0;
				end
				// day clamps by month
				if (d8 > 8'd31) d8 = 8'd31;
				if (mo == 4'd2 && d8 > 8'd29) d8 = 8'd29;
				if ((mo == 4'd4 || mo == 4'd6 || mo == 4'd9 || mo == 4'd11) &&
				    d8 > 8'd30) d8 = 8'd30;
			end
			default: begin
				state_d = ST_NORMAL;
			end
		endcase

		if (mode_d > MODE_WL) mode_d = MODE_TIME;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_NORMAL;
			mode_q   <= MODE_TIME;
			cursor_q <= 3'd0;
			loaded_q <= 1'b0;
			hour_q   <= 5'd0;
			minute_q <= 6'd0;
			second_q <= 6'd0;
			year_q   <= 7'd0;
			month_q  <= 4'd1;
			day_q    <= 5'd1;
		end else if (step) begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			cursor_q <= cursor_d;
			loaded_q <= loaded_d;
			hour_q   <= h8[4:0];
			minute_q <= m8[5:0];
			second_q <= s8[5:0];
			year_q   <= y8[6:0];
			month_q  <= mo;
			day_q    <= d8[4:0];
		end
	end

	// outcome of the step
	always_comb begin
		case (state_d)
			ST_MENU: res.ui_state = UI_MENU;
			ST_TIME: res.ui_state = UI_TIME;
			ST_DATE: res.ui_state = UI_DATE;
			default: res.ui_state = UI_NORMAL;
		endcase
		res.display_mode = mode_d;
		res.cursor       = cursor_d;
		res.save_strobe  = save;
		res.edit_hour    = h8[4:0];
		res.edit_minute  = m8[5:0];
		res.edit_second  = s8[5:0];
		res.edit_year    = y8[6:0];
		res.edit_month   = mo;
		res.edit_day     = d8[4:0];
	end

	// shadow only held while editing
	a_loaded_in_edit: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q |-> (state_q == ST_TIME || state_q == ST_DATE))
		else $error("shadow marked loaded outside an edit state");

	// leaving an edit state always drops the shadow
	a_exit_unloads: assert property (@(posedge clk) disable iff (!arst_n)
		(step && edit && !(state_d == ST_TIME || state_d == ST_DATE)) |=> !loaded_q)
		else $error("shadow still loaded after leaving edit");

endmodule

`default_nettype wire

// ===== rtl/clkmte_digits.sv =====
// ----------------------------------------------------------------------------
// clkmte_digits
// Forms the eight tube codes for the display mode from the live inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module clkmte_digits
	import clkmte_pkg::*;
(
	input  wire logic [2:0]  mode,
	input  wire item_t       item,
	output      logic [31:0] digits   // tube 0 in bits 31:28
);

	logic [3:0] hr_t, hr_u, mi_t, mi_u, se_t, se_u;
	logic [3:0] yr_t, yr_u, mo_t, mo_u, dy_t, dy_u;
	logic [4:0] yr_q;
	logic [7:0] hr_r, mi_r, se_r, yr_r, mo_r, dy_r;
	logic [4:0] hr_q, mi_q, se_q, mo_q, dy_q;
	logic [5:0] wl_idx;

	// tens and units of each live field
	always_comb begin
		hr_q = div10({3'd0, item.hour});
		mi_q = div10({2'd0, item.minute});
		se_q = div10({2'd0, item.second});
		yr_q = div10({1'd0, item.year});
		mo_q = div10({4'd0, item.month});
		dy_q = div10({3'd0, item.day});
		hr_r = mod10({3'd0, item.hour});
		mi_r = mod10({2'd0, item.minute});
		se_r = mod10({2'd0, item.second});
		yr_r = mod10({1'd0, item.year});
		mo_r = mod10({4'd0, item.month});
		dy_r = mod10({3'd0, item.day});
		hr_t = hr_q[3:0];
		hr_u = hr_r[3:0];
		mi_t = mi_q[3:0];
		mi_u = mi_r[3:0];
		se_t = se_q[3:0];
		se_u = se_r[3:0];
		// year tens digit taken modulo ten
		yr_t = (yr_q >= 5'd10) ? 4'(yr_q - 5'd10) : yr_q[3:0];
		yr_u = yr_r[3:0];
		mo_t = mo_q[3:0];
		mo_u = mo_r[3:0];
		dy_t = dy_q[3:0];
		dy_u = dy_r[3:0];
	end

	// worldline row: minute modulo 23
	always_comb begin
		if (item.minute >= 6'd46) begin
			wl_idx = item.minute - 6'd46;
		end else if (item.minute >= 6'd23) begin
			wl_idx = item.minute - 6'd23;
		end else begin
			wl_idx = item.minute;
		end
	end

	// tube codes per mode
	always_comb begin
		case (mode)
			MODE_WL_TIME: digits = {3'd0, item.minute[0], CODE_POINT,
			                        hr_t, hr_u, mi_t, mi_u, se_t, se_u};
			MODE_DATE:    digits = {yr_t, yr_u, CODE_SEP, mo_t, mo_u, CODE_SEP,
			                        dy_t, dy_u};
			MODE_WL_DATE: digits = {3'd0, item.day[0], CODE_POINT,
			                        yr_t, yr_u, mo_t, mo_u, dy_t, dy_u};
			MODE_TEMP:    digits = {CODE_SEP, CODE_SEP, CODE_SEP,
			                        item.temp_tens, item.temp_units, CODE_POINT,
			                        item.temp_tenths, item.temp_hundredths};
			MODE_WL:      digits = wl_row(wl_idx[4:0]);
			default:      digits = {hr_t, hr_u, CODE_SEP, mi_t, mi_u, CODE_SEP,
			                        se_t, se_u};
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/clock_menu_and_time_editor_core.sv =====
// ----------------------------------------------------------------------------
// clock_menu_and_time_editor_core
// Clock front panel: one item per loop pass in, one display/editor result out.
// ----------------------------------------------------------------------------
//  channel   | ports          | contents
//  ----------+----------------+-------------------------------------------------
//  input     | s_axis_*       | key, live time and date, four temperature digits
//  result    | m_axis_*       | tube codes, ui state, mode, cursor, save, shadow
//
//  An item passes through the input register and then the result register;
//  one item per cycle sustained while the result is taken.
//  The controller state is updated as the item moves into the result register.
//  A stalled result holds the result register; the input register still takes
//  one more item, after which input ready drops until the result is taken.
//  Reset clears the controller to normal state, time display, cursor 0.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_menu_and_time_editor_core
	import clkmte_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output      logic              s_axis_tready,
	// key, hour, minute, second, year, month, day,
	// temp_tens, temp_units, temp_tenths, temp_hundredths
	input  wire logic [ITEM_W-1:0] s_axis_tdata,
	output      logic              m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// digits, ui_state, display_mode, cursor, save_strobe, edit_hour,
	// edit_minute, edit_second, edit_year, edit_month, edit_day
	output      logic [RES_W-1:0]  m_axis_tdata
);

	item_t     item_s1;
	logic      valid_s1;
	result_t   res_q;
	logic      res_valid_q;
	logic      advance;
	ctrl_res_t ctrl_res;
	logic [31:0] digits;

	// handshake
	assign advance       = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
		end
	end

	// controller
	clkmte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (ctrl_res)
	);

	// tube codes for the mode after the step
	clkmte_digits u_digits (
		.mode   (ctrl_res.display_mode),
		.item   (item_s1),
		.digits (digits)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.ctrl   <= ctrl_res;
			res_q.digits <= digits;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {{(RES_W - $bits(result_t)){1'b0}}, res_q};

	// a save only ever lands back in normal state
	a_save_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.ctrl.save_strobe) |-> (res_q.ctrl.ui_state == UI_NORMAL))
		else $error("save strobe outside normal state");

	// display mode kept within its six modes
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.ctrl.display_mode <= MODE_WL))
		else $error("display mode out of range");

	// menu cursor within its three entries
	a_menu_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.ctrl.ui_state == UI_MENU) |-> (res_q.ctrl.cursor <= MENU_BACK))
		else $error("menu cursor out of range");

	// a held result is not overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !m_axis_tready) |=> !$past(advance) && $stable(res_q))
		else $error("stalled result changed");

endmodule

`default_nettype wire
